>>> hw/rtl/shell_line_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Needs nothing else; included inside module bodies.
`ifndef SHELL_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

>>> hw/rtl/slt_pkg.sv
// Types, character codes and lexer step functions for the line tokenizer.
// No dependencies; used by slt_decode, slt_burst and shell_line_tokenizer.
`timescale 1ns / 1ps

package slt_pkg;

   // Lexer modes, one-hot
   typedef enum logic [6:0] {
      MODE_BETWEEN = 7'b0000001,
      MODE_WORD    = 7'b0000010,
      MODE_SQ      = 7'b0000100,
      MODE_DQ      = 7'b0001000,
      MODE_DQ_BS   = 7'b0010000,
      MODE_BS      = 7'b0100000,
      MODE_GT      = 7'b1000000
   } mode_type;

   // Output event codes
   typedef enum logic [2:0] {
      EV_CHAR = 3'd0,
      EV_WEND = 3'd1,
      EV_PIPE = 3'd2,
      EV_ROUT = 3'd3,
      EV_APP  = 3'd4,
      EV_RIN  = 3'd5,
      EV_END  = 3'd6
   } event_kind_type;

   localparam int MaxEvents = 4;
   localparam int EvIdxW    = 2;
   localparam int EvCntW    = 3;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;

   typedef struct packed {
      logic [7:0] character;
      logic       has_character;
      logic       line_end;
   } item_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     text;
      logic           quoted;
   } event_type;

   typedef struct packed {
      event_type [MaxEvents-1:0] ev;
      logic [EvCntW-1:0]         count;
   } event_list_type;

   typedef struct packed {
      mode_type       mode;
      logic           quoted;
      event_list_type evl;
   } lex_state_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // Append one event to the list
   function automatic lex_state_type add_event(lex_state_type s, event_kind_type k,
                                               logic [7:0] t, logic q);
      lex_state_type r;
      r = s;
      if (s.evl.count < EvCntW'(MaxEvents)) begin
         r.evl.ev[s.evl.count[EvIdxW-1:0]].kind   = k;
         r.evl.ev[s.evl.count[EvIdxW-1:0]].text   = t;
         r.evl.ev[s.evl.count[EvIdxW-1:0]].quoted = q;
         r.evl.count = s.evl.count + EvCntW'(1);
      end
      return r;
   endfunction

   function automatic lex_state_type end_word(lex_state_type s);
      lex_state_type r;
      r = add_event(s, EV_WEND, CHAR_NUL, s.quoted);
      r.quoted = 1'b0;
      r.mode   = MODE_BETWEEN;
      return r;
   endfunction

   // Character seen while between tokens
   function automatic lex_state_type between_char(lex_state_type s, logic [7:0] c);
      lex_state_type r;
      r = s;
      if (is_space(c)) begin
         r = s;
      end else if (c == CHAR_PIPE) begin
         r = add_event(s, EV_PIPE, CHAR_NUL, 1'b0);
      end else if (c == CHAR_GT) begin
         r.mode = MODE_GT;
      end else if (c == CHAR_LT) begin
         r = add_event(s, EV_RIN, CHAR_NUL, 1'b0);
      end else if (c == CHAR_DQUOTE) begin
         r.quoted = 1'b1;
         r.mode   = MODE_DQ;
      end else if (c == CHAR_SQUOTE) begin
         r.quoted = 1'b1;
         r.mode   = MODE_SQ;
      end else begin
         r.quoted = 1'b0;
         if (c == CHAR_BSLASH) begin
            r.mode = MODE_BS;
         end else begin
            r      = add_event(r, EV_CHAR, c, 1'b0);
            r.mode = MODE_WORD;
         end
      end
      return r;
   endfunction

   // Character seen inside double quotes
   function automatic lex_state_type dq_char(lex_state_type s, logic [7:0] c);
      lex_state_type r;
      r = s;
      if (c == CHAR_DQUOTE) begin
         r.mode = MODE_WORD;
      end else if (c == CHAR_BSLASH) begin
         r.mode = MODE_DQ_BS;
      end else begin
         r = add_event(s, EV_CHAR, c, 1'b0);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/slt_decode.sv
// Single-pass lexer step: next mode, quote flag and up to four events for one item.
// Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_decode (
   input  slt_pkg::mode_type      mode_i,
   input  logic                   quoted_i,
   input  slt_pkg::item_type      item_i,
   output slt_pkg::lex_state_type next_o
);
   import slt_pkg::*;

   logic [7:0] c;
   assign c = item_i.character;

   always_comb begin
      lex_state_type s;
      s.mode   = mode_i;
      s.quoted = quoted_i;
      s.evl    = '0;

      // character handling
      if (item_i.has_character) begin
         case (s.mode)
            MODE_WORD: begin
               if (is_space(c)) begin
                  s = end_word(s);
               end else if ((c == CHAR_PIPE) || (c == CHAR_LT) || (c == CHAR_GT)) begin
                  s = end_word(s);
                  s = between_char(s, c);
               end else if (c == CHAR_DQUOTE) begin
                  s.mode = MODE_DQ;
               end else if (c == CHAR_SQUOTE) begin
                  s.mode = MODE_SQ;
               end else if (c == CHAR_BSLASH) begin
                  s.mode = MODE_BS;
               end else begin
                  s = add_event(s, EV_CHAR, c, 1'b0);
               end
            end
            MODE_SQ: begin
               if (c == CHAR_SQUOTE) begin
                  s.mode = MODE_WORD;
               end else begin
                  s = add_event(s, EV_CHAR, c, 1'b0);
               end
            end
            MODE_DQ: begin
               s = dq_char(s, c);
            end
            MODE_DQ_BS: begin
               s.mode = MODE_DQ;
               if ((c == CHAR_DQUOTE) || (c == CHAR_BSLASH)) begin
                  s = add_event(s, EV_CHAR, c, 1'b0);
               end else begin
                  s = add_event(s, EV_CHAR, CHAR_BSLASH, 1'b0);
                  s = dq_char(s, c);
               end
            end
            MODE_BS: begin
               s      = add_event(s, EV_CHAR, c, 1'b0);
               s.mode = MODE_WORD;
            end
            MODE_GT: begin
               s.mode = MODE_BETWEEN;
               if (c == CHAR_GT) begin
                  s = add_event(s, EV_APP, CHAR_NUL, 1'b0);
               end else begin
                  s = add_event(s, EV_ROUT, CHAR_NUL, 1'b0);
                  s = between_char(s, c);
               end
            end
            default: begin
               s.mode = MODE_BETWEEN;
               s      = between_char(s, c);
            end
         endcase
      end

      // line flush
      if (item_i.line_end) begin
         case (s.mode)
            MODE_WORD, MODE_SQ, MODE_DQ: begin
               s = end_word(s);
            end
            MODE_DQ_BS, MODE_BS: begin
               s = add_event(s, EV_CHAR, CHAR_BSLASH, 1'b0);
               s = end_word(s);
            end
            MODE_GT: begin
               s = add_event(s, EV_ROUT, CHAR_NUL, 1'b0);
            end
            default: begin
               s.mode = MODE_BETWEEN;
            end
         endcase
         s        = add_event(s, EV_END, CHAR_NUL, 1'b0);
         s.mode   = MODE_BETWEEN;
         s.quoted = 1'b0;
      end

      next_o = s;
   end

endmodule

>>> hw/rtl/slt_burst.sv
// Result register: holds one item's events; hands out one per cycle while ready.
// Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_burst (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_i,
   input  slt_pkg::event_list_type evl_i,
   output logic                    free_o,
   output logic                    rsp_valid_o,
   input  logic                    rsp_ready_i,
   output slt_pkg::event_type      event_o,
   output logic                    last_o
);
   import slt_pkg::*;

   logic                           valid_ff, valid_in;
   event_type [MaxEvents-1:0]      ev_ff, ev_in;
   logic [EvIdxW-1:0]              last_idx_ff, last_idx_in;
   logic [EvIdxW-1:0]              idx_ff, idx_in;
   logic [EvCntW-1:0]              cnt_m1;
   logic                           on_last;

   assign on_last = (idx_ff == last_idx_ff);
   assign free_o  = !valid_ff || (rsp_ready_i && on_last);
   assign cnt_m1  = evl_i.count - EvCntW'(1);

   // load a new run, step through the current one, or hold
   always_comb begin
      valid_in    = valid_ff;
      ev_in       = ev_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      if (load_i) begin
         valid_in    = 1'b1;
         ev_in       = evl_i.ev;
         last_idx_in = cnt_m1[EvIdxW-1:0];
         idx_in      = '0;
      end else if (valid_ff && rsp_ready_i) begin
         if (on_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + EvIdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff       <= ev_in;
      last_idx_ff <= last_idx_in;
   end

   assign rsp_valid_o = valid_ff;
   assign event_o     = ev_ff[idx_ff];
   assign last_o      = on_last;

endmodule

>>> hw/rtl/shell_line_tokenizer.sv
// An item is held in the input register until its events fit in the result register.
// Throughput: one item per cycle while each item yields at most one event and rsp_ready
// is high; more events (up to 4) hold the result register until taken, stalling input.
// Reset (synchronous, active high) empties both registers and returns the lexer
// to between tokens with the quote flag clear.
`timescale 1ns / 1ps

// Top level: input register, lexer state, decode step and result burst register.
// Depends on slt_pkg, slt_decode, slt_burst and shell_line_tokenizer_assert.svh.
module shell_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_has_character,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_kind,
   output logic [7:0] rsp_text_char,
   output logic       rsp_word_was_quoted,
   output logic       rsp_last_of_run
);
   import slt_pkg::*;
   `include "shell_line_tokenizer_assert.svh"

   logic          itm_valid_ff, itm_valid_in;
   item_type      itm_ff, itm_in;
   mode_type      mode_ff, mode_in;
   logic          quoted_ff, quoted_in;
   lex_state_type nxt;
   logic          has_events;
   logic          itm_take;
   logic          req_fire;
   logic          bst_free;
   logic          bst_load;
   event_type     bst_event;

   slt_decode u_decode (
      .mode_i   (mode_ff),
      .quoted_i (quoted_ff),
      .item_i   (itm_ff),
      .next_o   (nxt)
   );

   // an item leaves the input register once its events fit in the burst register
   assign has_events = (nxt.evl.count != '0);
   assign itm_take   = itm_valid_ff && (!has_events || bst_free);
   assign bst_load   = itm_take && has_events;
   assign req_ready  = !itm_valid_ff || itm_take;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      itm_valid_in = itm_valid_ff;
      itm_in       = itm_ff;
      if (req_fire) begin
         itm_valid_in           = 1'b1;
         itm_in.character       = req_character;
         itm_in.has_character   = req_has_character;
         itm_in.line_end        = req_line_end;
      end else if (itm_take) begin
         itm_valid_in = 1'b0;
      end
   end

   // lexer state advances when the item is consumed
   assign mode_in   = itm_take ? nxt.mode   : mode_ff;
   assign quoted_in = itm_take ? nxt.quoted : quoted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         itm_valid_ff <= 1'b0;
         mode_ff      <= MODE_BETWEEN;
         quoted_ff    <= 1'b0;
      end else begin
         itm_valid_ff <= itm_valid_in;
         mode_ff      <= mode_in;
         quoted_ff    <= quoted_in;
      end
   end

   always_ff @(posedge clock) begin
      itm_ff <= itm_in;
   end

   slt_burst u_burst (
      .clock       (clock),
      .reset       (reset),
      .load_i      (bst_load),
      .evl_i       (nxt.evl),
      .free_o      (bst_free),
      .rsp_valid_o (rsp_valid),
      .rsp_ready_i (rsp_ready),
      .event_o     (bst_event),
      .last_o      (rsp_last_of_run)
   );

   assign rsp_event_kind      = bst_event.kind;
   assign rsp_text_char       = bst_event.text;
   assign rsp_word_was_quoted = bst_event.quoted;

   // checks
   `SLT_ASSERT_IMPL(a_load_into_free, clock, reset, bst_load, bst_free)
   `SLT_ASSERT_IMPL(a_end_is_last, clock, reset, rsp_valid && (rsp_event_kind == EV_END), rsp_last_of_run)
   `SLT_ASSERT_NEXT(a_run_drains, clock, reset, rsp_valid && rsp_ready && rsp_last_of_run && !bst_load, !rsp_valid)
   `SLT_ASSERT_IMPL(a_text_on_char, clock, reset, rsp_valid && (rsp_text_char != 8'h00), rsp_event_kind == EV_CHAR)

endmodule

>>> tb/shell_line_tokenizer_test.sv
// Self-checking testbench for the shell command-line tokenizer.
// Needs slt_pkg and shell_line_tokenizer; predicts token events and checks every result.
`timescale 1ns / 1ps

module shell_line_tokenizer_test;
   import slt_pkg::*;

   localparam int QuietLimit = 500;

   // One expected token event
   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     text;
      logic           quoted;
      logic           last;
   } token_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_character = 8'h00;
   logic       req_has_character = 1'b0;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_text_char;
   logic       rsp_word_was_quoted;
   logic       rsp_last_of_run;

   // Predictor state and expected events
   mode_type  lex_mode = MODE_BETWEEN;
   logic      lex_quoted = 1'b0;
   token_type step_tokens[$];
   token_type pending_tokens[$];
   token_type got_token;

   int  errors = 0;
   int  items_sent = 0;
   int  events_checked = 0;
   int  kind_seen[0:7] = '{default: 0};
   int  quiet_cycles = 0;
   int  burst_left = 0;
   int  ready_run = 0;
   bit  idle_on = 1'b0;

   shell_line_tokenizer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_character       (req_character),
      .req_has_character   (req_has_character),
      .req_line_end        (req_line_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_text_char       (rsp_text_char),
      .rsp_word_was_quoted (rsp_word_was_quoted),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic bit is_blank(logic [7:0] c);
      return c inside {[8'd9:8'd13], 8'd32};
   endfunction

   // At most MaxEvents events per item
   function automatic void push_token(event_kind_type k, logic [7:0] t, logic q);
      token_type tok;
      if (step_tokens.size() < MaxEvents) begin
         tok = '{kind: k, text: t, quoted: q, last: 1'b0};
         step_tokens.insert(step_tokens.size(), tok);
      end
   endfunction

   function automatic void close_word();
      push_token(EV_WEND, CHAR_NUL, lex_quoted);
      lex_quoted = 1'b0;
      lex_mode   = MODE_BETWEEN;
   endfunction

   // Byte seen between tokens
   function automatic void start_token(logic [7:0] c);
      if (is_blank(c)) return;
      case (c)
         CHAR_PIPE:   push_token(EV_PIPE, CHAR_NUL, 1'b0);
         CHAR_GT:     lex_mode = MODE_GT;
         CHAR_LT:     push_token(EV_RIN, CHAR_NUL, 1'b0);
         CHAR_DQUOTE: begin
            lex_quoted = 1'b1;
            lex_mode   = MODE_DQ;
         end
         CHAR_SQUOTE: begin
            lex_quoted = 1'b1;
            lex_mode   = MODE_SQ;
         end
         CHAR_BSLASH: begin
            lex_quoted = 1'b0;
            lex_mode   = MODE_BS;
         end
         default: begin
            lex_quoted = 1'b0;
            push_token(EV_CHAR, c, 1'b0);
            lex_mode = MODE_WORD;
         end
      endcase
   endfunction

   // Byte seen inside unquoted word text
   function automatic void word_text(logic [7:0] c);
      if (is_blank(c)) begin
         close_word();
      end else begin
         case (c)
            CHAR_PIPE, CHAR_LT, CHAR_GT: begin
               close_word();
               start_token(c);
            end
            CHAR_DQUOTE: lex_mode = MODE_DQ;
            CHAR_SQUOTE: lex_mode = MODE_SQ;
            CHAR_BSLASH: lex_mode = MODE_BS;
            default:     push_token(EV_CHAR, c, 1'b0);
         endcase
      end
   endfunction

   // Byte seen inside double quotes
   function automatic void dq_text(logic [7:0] c);
      case (c)
         CHAR_DQUOTE: lex_mode = MODE_WORD;
         CHAR_BSLASH: lex_mode = MODE_DQ_BS;
         default:     push_token(EV_CHAR, c, 1'b0);
      endcase
   endfunction

   function automatic void take_byte(logic [7:0] c);
      case (lex_mode)
         MODE_WORD: word_text(c);
         MODE_SQ: begin
            if (c == CHAR_SQUOTE) lex_mode = MODE_WORD;
            else push_token(EV_CHAR, c, 1'b0);
         end
         MODE_DQ: dq_text(c);
         MODE_DQ_BS: begin
            lex_mode = MODE_DQ;
            // only a quote or a backslash is escaped; otherwise the backslash stays
            if (c == CHAR_DQUOTE || c == CHAR_BSLASH) begin
               push_token(EV_CHAR, c, 1'b0);
            end else begin
               push_token(EV_CHAR, CHAR_BSLASH, 1'b0);
               dq_text(c);
            end
         end
         MODE_BS: begin
            push_token(EV_CHAR, c, 1'b0);
            lex_mode = MODE_WORD;
         end
         MODE_GT: begin
            lex_mode = MODE_BETWEEN;
            if (c == CHAR_GT) begin
               push_token(EV_APP, CHAR_NUL, 1'b0);
            end else begin
               push_token(EV_ROUT, CHAR_NUL, 1'b0);
               start_token(c);
            end
         end
         default: begin
            lex_mode = MODE_BETWEEN;
            start_token(c);
         end
      endcase
   endfunction

   // Close whatever is open, then the line end event
   function automatic void flush_line();
      case (lex_mode)
         MODE_WORD, MODE_SQ, MODE_DQ: close_word();
         MODE_DQ_BS, MODE_BS: begin
            push_token(EV_CHAR, CHAR_BSLASH, 1'b0);
            close_word();
         end
         MODE_GT: push_token(EV_ROUT, CHAR_NUL, 1'b0);
         default: ;
      endcase
      push_token(EV_END, CHAR_NUL, 1'b0);
      lex_mode   = MODE_BETWEEN;
      lex_quoted = 1'b0;
   endfunction

   function automatic void predict_tokens(logic [7:0] c, logic has, logic fin);
      step_tokens.delete();
      if (has) take_byte(c);
      if (fin) flush_line();
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
   endfunction

   // ---------------- checking ----------------

   function automatic void check_field(string what, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected event, expected none, got kind %0d text %0d",
                     $time, rsp_event_kind, rsp_text_char);
            errors++;
         end else begin
            got_token = pending_tokens.pop_front();
            check_field("event_kind", got_token.kind, rsp_event_kind);
            check_field("text_char", got_token.text, rsp_text_char);
            check_field("word_was_quoted", got_token.quoted, rsp_word_was_quoted);
            check_field("last_of_run", got_token.last, rsp_last_of_run);
            kind_seen[got_token.kind]++;
            events_checked++;
         end
      end
   end

   // Receiver: always ready unless idle_on is set, then runs of ready and stall of random length
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_ready <= 1'b1;
         ready_run <= 0;
      end else if (ready_run == 0) begin
         rsp_ready <= ($urandom_range(0, 2) != 0);
         ready_run <= $urandom_range(1, 6);
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no item moved for %0d cycles, %0d events outstanding",
                  $time, quiet_cycles, pending_tokens.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- stimulus ----------------

   // Send one item; the sender idles between bursts when idle_on is set
   task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
      int gap;
      if (idle_on && burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_character     <= c;
      req_has_character <= has;
      req_line_end      <= fin;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(c, has, fin);
      items_sent++;
   endtask

   task automatic send_text(input string s, input bit close);
      foreach (s[i]) send_item(s[i], 1'b1, close && (i == s.len() - 1));
   endtask

   // Hold the sender until every expected event has come out
   task automatic wait_for_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   // Mostly shell-like bytes, some fully random
   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return 8'h61 + 8'($urandom_range(0, 25));
      if (pick < 45) return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                         : 8'($urandom_range(9, 13));
      if (pick < 53) return CHAR_PIPE;
      if (pick < 61) return CHAR_GT;
      if (pick < 66) return CHAR_LT;
      if (pick < 74) return CHAR_DQUOTE;
      if (pick < 81) return CHAR_SQUOTE;
      if (pick < 89) return CHAR_BSLASH;
      return 8'($urandom_range(0, 255));
   endfunction

   // Operators, word ended by an operator, byte extremes, '>' pending at line end
   task automatic test_operators();
      idle_on = 1'b1;
      send_item(CHAR_NUL, 1'b1, 1'b0);
      send_text("|b>>c<", 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(CHAR_GT, 1'b1, 1'b1);
      wait_for_tokens();
   endtask

   // Ignored item, then a line with no characters
   task automatic test_empty_items();
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   // Single quotes, escapes in double quotes, unterminated quote closed by line end;
   // the last item yields the full four events
   task automatic test_quoting();
      send_text("'x'\"\\\"\\\\\\q\\", 1'b0);
      send_item("x", 1'b1, 1'b1);
   endtask

   // Empty quoted word, then a backslash pending outside quotes at line end
   task automatic test_line_end_cases();
      send_text("\"\" \\", 1'b1);
   endtask

   // Random command lines, each closed on its last byte or by a bare end item
   task automatic test_random_lines(input int count, input bit idle);
      int sent;
      int len;
      bit fin_on_char;
      sent    = 0;
      idle_on = idle;
      while (sent < count) begin
         len         = $urandom_range(0, 14);
         fin_on_char = ($urandom_range(0, 1) == 1) && (len > 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(random_byte(), 1'b1, fin_on_char && (i == len - 1));
            sent++;
         end
         if (!fin_on_char) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_empty_items();
      test_quoting();
      test_line_end_cases();
      wait_for_tokens();
      test_random_lines(50, 1'b0);
      wait_for_tokens();
      test_random_lines(130, 1'b1);
      wait_for_tokens();
      repeat (10) @(posedge clock);
      $display("Sent %0d items, checked %0d events: %0d chars, %0d word ends, %0d line ends,",
               items_sent, events_checked, kind_seen[EV_CHAR], kind_seen[EV_WEND],
               kind_seen[EV_END]);
      $display("operators: %0d pipe, %0d out, %0d append, %0d in; %0d mismatches",
               kind_seen[EV_PIPE], kind_seen[EV_ROUT], kind_seen[EV_APP],
               kind_seen[EV_RIN], errors);
      if (errors == 0 && pending_tokens.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_decode.sv
hw/rtl/slt_burst.sv
hw/rtl/shell_line_tokenizer.sv
tb/shell_line_tokenizer_test.sv
